### rtl/core/counter_decay_task_scheduler_defines.svh
// Assertion helpers for the checker of the scheduler.
`ifndef COUNTER_DECAY_TASK_SCHEDULER_DEFINES_SVH
`define COUNTER_DECAY_TASK_SCHEDULER_DEFINES_SVH

// Same-cycle implication, masked during reset.
`define CDTS_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, masked during reset.
`define CDTS_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/cdts_pkg.sv
`default_nettype none

package cdts_pkg;

  localparam int NUM_TASKS_DEF = 64;
  // Widest slot index the table request can carry (NUM_TASKS up to 256).
  localparam int SLOT_MAX_W    = 8;
  localparam int CMD_W         = 3;
  localparam int SLOT_W        = 6;
  localparam int CNT_W         = 16;
  localparam int PRIO_W        = 8;
  localparam int DEPTH_W       = 8;

  typedef enum logic [1:0] {
    ST_EMPTY   = 2'd0,
    ST_RUNNING = 2'd1,
    ST_ZOMBIE  = 2'd2
  } run_state_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK    = 3'd0,
    CMD_YIELD   = 3'd1,
    CMD_EXIT    = 3'd2,
    CMD_CREATE  = 3'd3,
    CMD_PRE_DIS = 3'd4,
    CMD_PRE_EN  = 3'd5
  } cmd_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CUR,
    S_SCAN,
    S_FILL,
    S_DONE
  } sched_state_t;

  typedef struct packed {
    run_state_t               run_state;
    logic signed [CNT_W-1:0]  slice_counter;
    logic [PRIO_W-1:0]        task_prio;
    logic [DEPTH_W-1:0]       preempt_depth;
  } entry_t;

  typedef struct packed {
    logic                  rd_en;
    logic [SLOT_MAX_W-1:0] rd_addr;
    logic                  wr_en;
    logic [SLOT_MAX_W-1:0] wr_addr;
    entry_t                wr_data;
  } tbl_req_t;

  // Contents of a slot that has not been written since reset.
  function automatic entry_t reset_entry(input logic slot_zero);
    entry_t e;
    e.run_state     = slot_zero ? ST_RUNNING : ST_EMPTY;
    e.slice_counter = '0;
    e.task_prio     = slot_zero ? PRIO_W'(1) : '0;
    e.preempt_depth = '0;
    return e;
  endfunction

endpackage

`default_nettype wire

### rtl/core/cdts_table.sv
`default_nettype none

module cdts_table
  import cdts_pkg::*;
#(
  parameter int NUM_TASKS = NUM_TASKS_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire tbl_req_t req,
  output entry_t        rd_entry
);

  localparam int IW = $clog2(NUM_TASKS);

  entry_t               mem [NUM_TASKS];
  logic [NUM_TASKS-1:0] written;
  entry_t               rd_data;
  logic                 rd_written;
  logic                 rd_zero;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr[IW-1:0]] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data    <= mem[req.rd_addr[IW-1:0]];
      rd_written <= written[req.rd_addr[IW-1:0]];
      rd_zero    <= (req.rd_addr[IW-1:0] == '0);
    end
  end

  // Per-slot written flags stand in for clearing the array after reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
    end else if (req.wr_en) begin
      written[req.wr_addr[IW-1:0]] <= 1'b1;
    end
  end

  assign rd_entry = rd_written ? rd_data : reset_entry(rd_zero);

endmodule

`default_nettype wire

### rtl/core/counter_decay_task_scheduler.sv
// Create and unknown commands go straight from idle to the result state; preempt commands
// and ticks that do not reschedule first rewrite the current slot; a reschedule adds a scan
// of all NUM_TASKS slots and, when the best counter is zero, a refill pass and a second scan,
// each paced by one table read a cycle.
// One request is in flight at a time; a new one is taken the cycle after its result
// is registered. Synchronous reset; the table reads as its reset contents at once.
`default_nettype none

module counter_decay_task_scheduler
  import cdts_pkg::*;
#(
  parameter int NUM_TASKS = NUM_TASKS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [CMD_W-1:0]  cmd,
  input  wire logic [SLOT_W-1:0] task_slot,
  input  wire logic [PRIO_W-1:0] task_priority,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic                   switched,
  output logic [SLOT_W-1:0]      next_task,
  output logic [SLOT_W-1:0]      prev_task,
  output logic                   no_runnable
);

  localparam int IW = $clog2(NUM_TASKS);
  localparam logic [IW:0] CNT_END = (IW+1)'(NUM_TASKS);
  localparam logic signed [CNT_W-1:0] NO_BEST = '1;
  localparam logic signed [CNT_W-1:0] CNT_MIN = {1'b1, {(CNT_W-1){1'b0}}};
  localparam logic signed [CNT_W-1:0] CNT_ONE = CNT_W'(1);
  localparam logic [DEPTH_W-1:0] DEPTH_MAX = '1;

  sched_state_t            state, state_next;
  cmd_t                    cmd_q, cmd_q_next;
  logic [IW-1:0]           cur, cur_next;
  logic [IW-1:0]           prev_q, prev_q_next;
  logic [IW:0]             cnt, cnt_next;
  logic signed [CNT_W-1:0] best_c, best_c_next;
  logic [IW-1:0]           best_idx, best_idx_next;
  logic                    refilled, refilled_next;
  logic                    none_q, none_q_next;
  logic                    out_load;

  tbl_req_t                req;
  entry_t                  e;

  // Datapath terms shared by the next-state and output logic.
  logic [IW-1:0]           proc_idx;
  logic                    scan_end;
  logic                    cand;
  logic signed [CNT_W-1:0] best_c_upd;
  logic [IW-1:0]           best_idx_upd;
  logic                    found;
  entry_t                  cur_wr;
  logic                    cur_sched;
  entry_t                  fill_wr;
  logic                    fill_en;
  logic signed [CNT_W-1:0] dec;
  logic                    create_ok;

  cdts_table #(
    .NUM_TASKS (NUM_TASKS)
  ) u_table (
    .clk      (clk),
    .rst      (rst),
    .req      (req),
    .rd_entry (e)
  );

  always_comb begin
    proc_idx     = IW'(cnt - 1'b1);
    scan_end     = (cnt == CNT_END);
    cand         = (cnt != '0) && (e.run_state == ST_RUNNING) &&
                   ($signed(e.slice_counter) > best_c);
    best_c_upd   = cand ? $signed(e.slice_counter) : best_c;
    best_idx_upd = cand ? proc_idx : best_idx;
    found        = !best_c_upd[CNT_W-1];
    create_ok    = int'(task_slot) < NUM_TASKS;

    dec       = ($signed(e.slice_counter) == CNT_MIN) ? CNT_MIN :
                $signed(e.slice_counter) - CNT_ONE;
    cur_wr    = e;
    cur_sched = 1'b0;
    case (cmd_q)
      CMD_TICK: begin
        if (dec > 0 || e.preempt_depth != '0) begin
          cur_wr.slice_counter = dec;
        end else begin
          cur_wr.slice_counter = '0;
          cur_sched            = 1'b1;
        end
      end
      CMD_YIELD: begin
        cur_wr.slice_counter = '0;
        cur_sched            = 1'b1;
      end
      CMD_EXIT: begin
        cur_wr.run_state     = ST_ZOMBIE;
        cur_wr.slice_counter = '0;
        cur_sched            = 1'b1;
      end
      CMD_PRE_DIS: begin
        if (e.preempt_depth != DEPTH_MAX) begin
          cur_wr.preempt_depth = e.preempt_depth + 1'b1;
        end
      end
      CMD_PRE_EN: begin
        if (e.preempt_depth != '0) begin
          cur_wr.preempt_depth = e.preempt_depth - 1'b1;
        end
      end
      default: begin
        cur_wr = e;
      end
    endcase

    // Halving plus at most 255 stays well inside the counter range.
    fill_wr               = e;
    fill_wr.slice_counter = ($signed(e.slice_counter) >>> 1) +
                            $signed(CNT_W'(e.task_prio));
    fill_en               = (cnt != '0) && (e.run_state != ST_EMPTY);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          case (cmd_t'(cmd))
            CMD_TICK, CMD_YIELD, CMD_EXIT, CMD_PRE_DIS, CMD_PRE_EN: state_next = S_CUR;
            default: state_next = S_DONE;
          endcase
        end
      end
      S_CUR: state_next = cur_sched ? S_SCAN : S_DONE;
      S_SCAN: begin
        if (scan_end) begin
          if (found && best_c_upd == '0 && !refilled) begin
            state_next = S_FILL;
          end else begin
            state_next = S_DONE;
          end
        end
      end
      S_FILL: begin
        if (scan_end) begin
          state_next = S_SCAN;
        end
      end
      S_DONE: begin
        if (!out_valid || out_ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    req           = '0;
    in_ready      = 1'b0;
    out_load      = 1'b0;
    cmd_q_next    = cmd_q;
    cur_next      = cur;
    prev_q_next   = prev_q;
    cnt_next      = cnt;
    best_c_next   = best_c;
    best_idx_next = best_idx;
    refilled_next = refilled;
    none_q_next   = none_q;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd_q_next  = cmd_t'(cmd);
          prev_q_next = cur;
          none_q_next = 1'b0;
          req.rd_en   = 1'b1;
          req.rd_addr = SLOT_MAX_W'(cur);
          if (cmd_t'(cmd) == CMD_CREATE && create_ok) begin
            req.wr_en                 = 1'b1;
            req.wr_addr               = SLOT_MAX_W'(task_slot);
            req.wr_data.run_state     = ST_RUNNING;
            req.wr_data.slice_counter = $signed(CNT_W'(task_priority));
            req.wr_data.task_prio     = task_priority;
            req.wr_data.preempt_depth = '0;
          end
        end
      end
      S_CUR: begin
        req.wr_en     = 1'b1;
        req.wr_addr   = SLOT_MAX_W'(cur);
        req.wr_data   = cur_wr;
        cnt_next      = '0;
        best_c_next   = NO_BEST;
        best_idx_next = '0;
        refilled_next = 1'b0;
      end
      S_SCAN: begin
        req.rd_en     = !scan_end;
        req.rd_addr   = SLOT_MAX_W'(cnt[IW-1:0]);
        cnt_next      = cnt + 1'b1;
        best_c_next   = best_c_upd;
        best_idx_next = best_idx_upd;
        if (scan_end) begin
          cnt_next = '0;
          if (!found) begin
            none_q_next = 1'b1;
          end else if (best_c_upd == '0 && !refilled) begin
            refilled_next = 1'b1;
          end else begin
            cur_next = best_idx_upd;
          end
        end
      end
      S_FILL: begin
        req.rd_en   = !scan_end;
        req.rd_addr = SLOT_MAX_W'(cnt[IW-1:0]);
        req.wr_en   = fill_en;
        req.wr_addr = SLOT_MAX_W'(proc_idx);
        req.wr_data = fill_wr;
        cnt_next    = cnt + 1'b1;
        if (scan_end) begin
          cnt_next      = '0;
          best_c_next   = NO_BEST;
          best_idx_next = '0;
        end
      end
      S_DONE: begin
        out_load = !out_valid || out_ready;
      end
      default: begin
        req = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cur       <= '0;
      cnt       <= '0;
      refilled  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state    <= state_next;
      cur      <= cur_next;
      cnt      <= cnt_next;
      refilled <= refilled_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cmd_q    <= cmd_q_next;
    prev_q   <= prev_q_next;
    best_c   <= best_c_next;
    best_idx <= best_idx_next;
    none_q   <= none_q_next;
    if (out_load) begin
      switched    <= (cur != prev_q);
      next_task   <= SLOT_W'(cur);
      prev_task   <= SLOT_W'(prev_q);
      no_runnable <= none_q;
    end
  end

endmodule

`default_nettype wire

### rtl/core/cdts_checker.sv
`default_nettype none
`include "counter_decay_task_scheduler_defines.svh"

module cdts_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic       switched,
  input wire logic [5:0] next_task,
  input wire logic [5:0] prev_task,
  input wire logic       no_runnable
);

  // A result that does not switch must report the same task on both sides.
  `CDTS_ASSERT_IMP(a_keep_task, clk, rst, out_valid && !switched, next_task == prev_task, "task changed without switch")

  // When nothing could run, the current task is kept.
  `CDTS_ASSERT_IMP(a_none_keeps, clk, rst, out_valid && no_runnable, !switched, "switch reported with no runnable task")

  // Requests are handled one at a time, so the port closes right after one is taken.
  `CDTS_ASSERT_NXT(a_busy_after_req, clk, rst, in_valid && in_ready, !in_ready, "second request taken while busy")

  `CDTS_ASSERT_NXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(next_task) && $stable(prev_task) && $stable(switched) && $stable(no_runnable), "stalled result changed")

endmodule

bind counter_decay_task_scheduler cdts_checker u_cdts_checker (.*);

`default_nettype wire
